FILE: hw/rtl/reversible_list_with_search_macros.svh
// Assertion helpers for the list block.
`ifndef REVERSIBLE_LIST_WITH_SEARCH_MACROS_SVH
`define REVERSIBLE_LIST_WITH_SEARCH_MACROS_SVH

// same-cycle implication
`define RLS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rls_pkg.sv
`default_nettype none

package rls_pkg;

    localparam int unsigned DefDepth = 16;
    localparam int unsigned DataW    = 32;

    localparam logic [2:0] ACT_INSERT  = 3'd0;
    localparam logic [2:0] ACT_DELETE  = 3'd1;
    localparam logic [2:0] ACT_SEARCH  = 3'd2;
    localparam logic [2:0] ACT_CLEAR   = 3'd3;
    localparam logic [2:0] ACT_REVERSE = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DEL_EMPTY = 2'd1;
    localparam logic [1:0] ST_INS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DataW-1:0]  value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]               status;
        logic                     found;
        logic signed [DataW-1:0]  front_value;
        logic [4:0]               count;
        logic                     is_empty;
    } t_out_word;

    typedef struct packed {
        logic take;
        logic exec;
        logic srch;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic srch_go;
        logic srch_done;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/rls_ifs.sv
`default_nettype none

interface rls_in_if import rls_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rls_out_if import rls_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rls_ram.sv
`default_nettype none

module rls_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rls_ctrl.sv
`default_nettype none

module rls_ctrl import rls_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SRCH  = 5'b00100,
        S_FRONT = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.srch_go ? S_SRCH : S_FRONT;
            end
            S_SRCH: begin
                o_cmd.srch = 1'b1;
                if (i_stat.srch_done) begin
                    n_state = S_FRONT;
                end
            end
            S_FRONT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rls_dp.sv
`default_nettype none

module rls_dp import rls_pkg::*; #(
    parameter int unsigned DEPTH = DefDepth
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_cmd,
    output t_stat          o_stat,
    input  wire t_in_word  i_in_word,
    output t_out_word      o_out_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = AW + 2;

    function automatic logic [AW-1:0] ring_fwd(input logic [AW-1:0] p, input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(p) + SW'(k);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] p, input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(p) + SW'(DEPTH) - SW'(k);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [AW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_count, n_count;
    logic             r_rev, n_rev;
    logic [1:0]       n_status, r_status;
    t_in_word         r_word;
    logic             r_found;
    logic [CW-1:0]    r_idx;
    logic             r_cmp_vld;
    t_out_word        r_out;
    logic             r_out_valid;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [DataW-1:0] rd_data;
    logic [AW-1:0]    srch_slot;
    logic             more;
    logic             hit;
    logic             issue;
    logic             is_empty;

    assign is_empty  = (r_count == '0);
    assign srch_slot = r_rev ? ring_back(r_pos, r_idx) : ring_fwd(r_pos, r_idx);
    assign more      = (r_idx < r_count);
    assign hit       = r_cmp_vld && (rd_data == r_word.value);
    assign issue     = more && !hit;
    assign raddr     = i_cmd.srch ? srch_slot : r_pos;

    assign o_stat.srch_go   = (r_word.action == ACT_SEARCH) && !is_empty;
    assign o_stat.srch_done = hit || (!more && !r_cmp_vld);
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

    // action decode
    always_comb begin
        n_pos    = r_pos;
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = ST_OK;
        we       = 1'b0;
        waddr    = r_pos;
        unique case (r_word.action)
            ACT_INSERT: begin
                if (r_count >= CW'(DEPTH)) begin
                    n_status = ST_INS_FULL;
                end else begin
                    n_pos   = r_rev ? ring_fwd(r_pos, CW'(1)) : ring_back(r_pos, CW'(1));
                    we      = i_cmd.exec;
                    waddr   = n_pos;
                    n_count = r_count + CW'(1);
                end
            end
            ACT_DELETE: begin
                if (is_empty) begin
                    n_status = ST_DEL_EMPTY;
                end else begin
                    n_pos   = r_rev ? ring_back(r_pos, CW'(1)) : ring_fwd(r_pos, CW'(1));
                    n_count = r_count - CW'(1);
                end
            end
            ACT_CLEAR: begin
                n_pos   = '0;
                n_count = '0;
                n_rev   = 1'b0;
            end
            ACT_REVERSE: begin
                if (!is_empty) begin
                    n_pos = r_rev ? ring_back(r_pos, r_count - CW'(1))
                                  : ring_fwd(r_pos, r_count - CW'(1));
                end
                n_rev = !r_rev;
            end
            default: begin
            end
        endcase
    end

    rls_ram #(
        .WIDTH (DataW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_word.value),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_pos     <= n_pos;
                r_count   <= n_count;
                r_rev     <= n_rev;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.srch) begin
                r_cmp_vld <= issue;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_word <= i_in_word;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_found  <= 1'b0;
            r_idx    <= '0;
        end else if (i_cmd.srch) begin
            r_found <= r_found | hit;
            if (issue) begin
                r_idx <= r_idx + CW'(1);
            end
        end
        if (i_cmd.load_out) begin
            r_out.status      <= r_status;
            r_out.found       <= r_found;
            r_out.front_value <= is_empty ? '0 : rd_data;
            r_out.count       <= 5'(r_count);
            r_out.is_empty    <= is_empty;
        end
    end

    assign o_out_word  = r_out;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/reversible_list_with_search.sv
// The sequential controller steps each input word through IDLE (word taken), EXEC (list
// updated), SRCH (searches of a non-empty list only, one entry per cycle until a hit or
// the list end), FRONT and DONE, which loads the result into the output register.
// A new word is taken only after that load, and DONE waits while the previous result
// word is stalled at the output.
// Reset (synchronous, active low) empties the list, clears direction and front; RAM kept.
`default_nettype none

`include "reversible_list_with_search_macros.svh"

module reversible_list_with_search import rls_pkg::*; #(
    parameter int unsigned DEPTH = DefDepth
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rls_in_if.sink     i_in,
    rls_out_if.source  o_out
);

    t_cmd  cmd;
    t_stat stat;

    rls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rls_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_word   (i_in.payload),
        .o_out_word  (o_out.payload),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready)
    );

    `RLS_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in.valid && i_in.ready,
        !i_in.ready, "input taken while a word is in work")
    `RLS_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, cmd.load_out, o_out.valid,
        "result load did not raise valid")
    `RLS_ASSERT_NOW(a_empty_front_zero, i_clk, i_rst_n,
        o_out.valid && o_out.payload.is_empty,
        o_out.payload.front_value == '0 && o_out.payload.count == '0,
        "empty list with nonzero front or count")
    `RLS_ASSERT_NOW(a_found_ok, i_clk, i_rst_n, o_out.valid && o_out.payload.found,
        !o_out.payload.is_empty && o_out.payload.status == ST_OK,
        "hit reported on empty list or bad status")

endmodule

`default_nettype wire

FILE: sim/list_checker.sv
`timescale 1ns / 1ps

module list_checker import rls_pkg::*; #(
    parameter int unsigned DEPTH = DefDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rls_in_if    i_in_mon,
    rls_out_if   i_out_mon,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_hits
);

    logic signed [DataW-1:0] shadow_entries [DEPTH];
    int unsigned             shadow_front;
    int unsigned             shadow_count;
    logic                    shadow_flipped;

    t_out_word list_replies_q [$];
    int        err_cnt;
    int        checked_cnt;
    int        hit_cnt;

    function automatic int unsigned slot_at(int unsigned idx);
        if (shadow_flipped) begin
            return (shadow_front + DEPTH - (idx % DEPTH)) % DEPTH;
        end
        return (shadow_front + idx) % DEPTH;
    endfunction

    function automatic t_out_word apply_list_action(t_in_word w);
        t_out_word r;
        r = '0;
        case (w.action)
            ACT_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_INS_FULL;
                end else begin
                    shadow_front = shadow_flipped ? (shadow_front + 1) % DEPTH
                                                  : (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_entries[shadow_front] = w.value;
                    shadow_count++;
                end
            end
            ACT_DELETE: begin
                if (shadow_count == 0) begin
                    r.status = ST_DEL_EMPTY;
                end else begin
                    shadow_front = shadow_flipped ? (shadow_front + DEPTH - 1) % DEPTH
                                                  : (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
            end
            ACT_SEARCH: begin
                for (int unsigned i = 0; i < shadow_count; i++) begin
                    if (shadow_entries[slot_at(i)] == w.value) begin
                        r.found = 1'b1;
                        break;
                    end
                end
            end
            ACT_CLEAR: begin
                shadow_count   = 0;
                shadow_front   = 0;
                shadow_flipped = 1'b0;
            end
            ACT_REVERSE: begin
                if (shadow_count > 0) begin
                    shadow_front = slot_at(shadow_count - 1);
                end
                shadow_flipped = ~shadow_flipped;
            end
            default: ;
        endcase
        r.front_value = (shadow_count > 0) ? shadow_entries[shadow_front] : '0;
        r.count       = shadow_count[4:0];
        r.is_empty    = (shadow_count == 0);
        return r;
    endfunction

    task automatic compare_field(string fname, logic [DataW-1:0] want,
                                 logic [DataW-1:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected 0x%h, got 0x%h", $time, fname, want, seen);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word seen;
        if (!i_rst_n) begin
            shadow_front   = 0;
            shadow_count   = 0;
            shadow_flipped = 1'b0;
            list_replies_q.delete();
            err_cnt        = 0;
            checked_cnt    = 0;
            hit_cnt        = 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                seen = i_out_mon.payload;
                if (list_replies_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %p",
                             $time, seen);
                    err_cnt++;
                end else begin
                    want = list_replies_q.pop_front();
                    compare_field("status", DataW'(want.status), DataW'(seen.status));
                    compare_field("found", DataW'(want.found), DataW'(seen.found));
                    compare_field("front_value", want.front_value, seen.front_value);
                    compare_field("count", DataW'(want.count), DataW'(seen.count));
                    compare_field("is_empty", DataW'(want.is_empty), DataW'(seen.is_empty));
                    checked_cnt++;
                    if (seen.found === 1'b1) begin
                        hit_cnt++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                list_replies_q.push_back(apply_list_action(i_in_mon.payload));
            end
        end
        o_errors  <= err_cnt;
        o_pending <= list_replies_q.size();
        o_checked <= checked_cnt;
        o_hits    <= hit_cnt;
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top import rls_pkg::*; ();

    localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
    localparam int         PHASE_WORDS      = 306;
    localparam int         POOL_MAX         = 24;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic clk;
    logic rst_n;

    rls_in_if  in_if ();
    rls_out_if out_if ();

    int errors;
    int pending;
    int checked;
    int hits;

    int send_idle_pct;
    int recv_stall_pct;
    int act_tally [8];

    logic signed [DataW-1:0] value_pool [$];

    reversible_list_with_search #(.DEPTH(DefDepth)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    list_checker #(.DEPTH(DefDepth)) u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in_mon  (in_if),
        .i_out_mon (out_if),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked),
        .o_hits    (hits)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #8_000_000;
        $display("reversible_list_with_search verification failed");
        $finish;
    end

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_word(logic [2:0] act, logic signed [DataW-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid          <= 1'b1;
        in_if.payload.action <= act;
        in_if.payload.value  <= val;
        @(posedge clk);
        while (!in_if.ready) begin
            @(posedge clk);
        end
        act_tally[act]++;
        if (act == ACT_INSERT) begin
            value_pool.push_back(val);
            if (value_pool.size() > POOL_MAX) begin
                void'(value_pool.pop_front());
            end
        end
    endtask

    function automatic logic signed [DataW-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(DataW-1){1'b0}}};
            1: return {1'b0, {(DataW-1){1'b1}}};
            2, 3: return DataW'($urandom_range(0, 7));
            4: return -DataW'($urandom_range(1, 4));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_action(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (r == 0) begin
            return ACT_CLEAR;
        end
        if (r == 1) begin
            return ACT_UNUSED_FIRST + 3'($urandom_range(0, 2));
        end
        case (mode)
            MODE_FILL:  return (r < 60) ? ACT_INSERT : (r < 78) ? ACT_SEARCH :
                               (r < 88) ? ACT_DELETE : ACT_REVERSE;
            MODE_DRAIN: return (r < 55) ? ACT_DELETE : (r < 78) ? ACT_SEARCH :
                               (r < 88) ? ACT_INSERT : ACT_REVERSE;
            default:    return (r < 35) ? ACT_INSERT : (r < 60) ? ACT_SEARCH :
                               (r < 82) ? ACT_DELETE : ACT_REVERSE;
        endcase
    endfunction

    task automatic send_random_word(int mode);
        logic [2:0]              act;
        logic signed [DataW-1:0] val;
        act = pick_action(mode);
        val = rand_value();
        if (act == ACT_SEARCH && value_pool.size() > 0 && $urandom_range(0, 99) < 60) begin
            val = value_pool[$urandom_range(0, value_pool.size() - 1)];
        end
        send_word(act, val);
    endtask

    task automatic run_directed();
        send_word(ACT_DELETE, 32'sd0);
        send_word(ACT_SEARCH, 32'sd0);
        send_word(ACT_REVERSE, 32'sd0);
        send_word(ACT_UNUSED_FIRST, 32'sd9);
        send_word(ACT_INSERT, 32'sh7fff_ffff);
        send_word(ACT_INSERT, 32'sh0000_0000);
        send_word(ACT_INSERT, 32'shffff_ffff);
        send_word(ACT_INSERT, 32'sh5555_5555);
        send_word(ACT_INSERT, 32'shaaaa_aaaa);
        send_word(ACT_INSERT, 32'sh8000_0000);
        send_word(ACT_SEARCH, 32'sh5555_5555);
        send_word(ACT_SEARCH, 32'sd12345);
        send_word(ACT_REVERSE, 32'sd0);
        send_word(ACT_DELETE, 32'sd0);
        send_word(ACT_SEARCH, 32'sh7fff_ffff);
        for (int i = 0; i < 11; i++) begin
            send_word(ACT_INSERT, 32'(i * 3 + 100));
        end
        send_word(ACT_INSERT, 32'sd77);
        send_word(ACT_CLEAR, 32'sd0);
    endtask

    initial begin
        int send_pcts [4];
        int recv_pcts [4];
        int mode;
        int burst_left;
        send_pcts = '{0, 71, 0, 24};
        recv_pcts = '{0, 0, 71, 24};
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        rst_n                <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.payload.action <= ACT_INSERT;
        in_if.payload.value  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        burst_left = 0;
        mode       = MODE_FILL;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (burst_left == 0) begin
                    mode       = $urandom_range(MODE_FILL, MODE_MIXED);
                    burst_left = $urandom_range(8, 40);
                end
                burst_left--;
                send_random_word(mode);
            end
        end
        in_if.valid    <= 1'b0;
        recv_stall_pct = 0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (64) @(posedge clk);

        $display("Sent words: %0d insert, %0d delete, %0d search, %0d clear, %0d reverse, %0d spare",
                 act_tally[ACT_INSERT], act_tally[ACT_DELETE], act_tally[ACT_SEARCH],
                 act_tally[ACT_CLEAR], act_tally[ACT_REVERSE],
                 act_tally[5] + act_tally[6] + act_tally[7]);
        $display("Checked %0d result words over four flow-control phases, %0d search hits",
                 checked, hits);
        if (errors == 0 && pending == 0) begin
            $display("reversible_list_with_search verification clean");
        end else begin
            $display("reversible_list_with_search verification failed");
        end
        $finish;
    end

endmodule
